>>> design/tgrg_pkg.sv
// ----------------------------------------------------------------------------
// tgrg_pkg
// Shared constants, types and the 5x7 glyph table of the text glyph
// rectangle generator.
// ----------------------------------------------------------------------------
package tgrg_pkg;

  localparam int COORD_BITS = 16;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
  localparam int CHAR_PITCH = 5 + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [GLYPH_BITS-1:0] glyph_t;
  typedef logic [5:0]            glyph_idx_t;

  localparam logic [7:0] CODE_COPYRIGHT = 8'hA9;

  function automatic glyph_idx_t glyph_index(input logic [7:0] code);
    logic [7:0] u;
    glyph_idx_t g;
    u = code;
    if (u >= 8'h61 && u <= 8'h7A) begin
      u = u - 8'h20;
    end
    if (u >= 8'h30 && u <= 8'h39) begin
      g = glyph_idx_t'(u - 8'h30) + 6'd1;
    end else if (u >= 8'h41 && u <= 8'h5A) begin
      g = glyph_idx_t'(u - 8'h41) + 6'd11;
    end else begin
      case (u)
        8'h3F:          g = 6'd37;
        8'h3A:          g = 6'd38;
        8'h2E:          g = 6'd39;
        8'h2C:          g = 6'd40;
        8'h2D:          g = 6'd41;
        8'h2B:          g = 6'd42;
        8'h2F:          g = 6'd43;
        8'h3D:          g = 6'd44;
        8'h28:          g = 6'd45;
        8'h29:          g = 6'd46;
        CODE_COPYRIGHT: g = 6'd47;
        default:        g = 6'd0;
      endcase
    end
    return g;
  endfunction

  // row 0 in the top bits, each row msb first
  function automatic glyph_t glyph_bits(input glyph_idx_t g);
    glyph_t b;
    case (g)
      6'd1:  b = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      6'd2:  b = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd3:  b = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd4:  b = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      6'd5:  b = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      6'd6:  b = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      6'd7:  b = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      6'd8:  b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      6'd9:  b = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      6'd10: b = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      6'd11: b = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd12: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      6'd13: b = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      6'd14: b = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      6'd15: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      6'd16: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd17: b = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      6'd18: b = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd19: b = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd20: b = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
      6'd21: b = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      6'd22: b = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      6'd23: b = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      6'd24: b = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      6'd25: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd26: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd27: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      6'd28: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      6'd29: b = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd30: b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd31: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd32: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd33: b = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      6'd34: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      6'd35: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd36: b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      6'd37: b = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
      6'd38: b = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      6'd39: b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04};
      6'd40: b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
      6'd41: b = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      6'd42: b = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
      6'd43: b = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
      6'd44: b = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
      6'd45: b = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      6'd46: b = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      6'd47: b = {5'h0E, 5'h11, 5'h16, 5'h14, 5'h16, 5'h11, 5'h0E};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

>>> design/text_glyph_rect_generator_unit.sv
// ----------------------------------------------------------------------------
// text_glyph_rect_generator_unit
// Turns one character into filled squares, one per set pixel of its 5x7
// glyph, and advances the pen.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | char_code start_text pos_x pos_y scale color
//  out_    | output    | out_valid/out_stall| rect_x0 rect_y0 rect_x1 rect_y1 fill_color last_rect
//
//  a sequencer walks the glyph cells one per cycle while the output is free,
//  ending after the last set pixel; a blank glyph is never scanned
//  in_stall is high while a character is being scanned
//  a stalled output holds the scan in place
//  reset clears the pen to zero and the scan state
// ----------------------------------------------------------------------------
module text_glyph_rect_generator_unit import tgrg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_start_text,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [3:0]  in_scale,
  input  logic [15:0] in_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_rect_x0,
  output logic [15:0] out_rect_y0,
  output logic [15:0] out_rect_x1,
  output logic [15:0] out_rect_y1,
  output logic [15:0] out_fill_color,
  output logic        out_last_rect
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic        state_r, state_nxt;
  coord_t      pen_x_r, pen_x_nxt;
  coord_t      pen_y_r, pen_y_nxt;
  coord_t      cur_x_r, cur_x_nxt;
  coord_t      cur_y_r, cur_y_nxt;
  coord_t      row_x_r, row_x_nxt;
  glyph_t      glyph_r, glyph_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [3:0]  side_r, side_nxt;
  logic [15:0] color_r, color_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] x0_r, y0_r, x1_r, y1_r, fc_r;
  logic        last_r;

  logic        in_xfer;
  logic        out_free;
  logic        step;
  logic        emit;
  coord_t      base_x, base_y;
  coord_t      x1_sum, y1_sum;
  coord_t      side_c;
  logic [6:0]  advance;

  function automatic logic [15:0] to_field(input coord_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[15:0];
  endfunction

  function automatic coord_t from_field(input logic [15:0] f);
    logic [31:0] w;
    w = 32'(signed'(f));
    return w[COORD_BITS-1:0];
  endfunction

  assign in_stall  = (state_r == ST_SCAN);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign step      = (state_r == ST_SCAN) && out_free;
  assign emit      = step && glyph_r[GLYPH_BITS-1];

  assign side_c  = coord_t'(side_r);
  assign x1_sum  = cur_x_r + side_c - coord_t'(1);
  assign y1_sum  = cur_y_r + side_c - coord_t'(1);
  assign advance = 7'({in_scale, 2'b00}) + 7'({in_scale, 1'b0});

  always_comb begin
    base_x = in_start_text ? from_field(in_pos_x) : pen_x_r;
    base_y = in_start_text ? from_field(in_pos_y) : pen_y_r;
  end

  always_comb begin
    state_nxt     = state_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    row_x_nxt     = row_x_r;
    glyph_nxt     = glyph_r;
    col_nxt       = col_r;
    side_nxt      = side_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          glyph_nxt = glyph_bits(glyph_index(in_char_code));
          pen_x_nxt = base_x + coord_t'(advance);
          pen_y_nxt = base_y;
          cur_x_nxt = base_x;
          row_x_nxt = base_x;
          cur_y_nxt = base_y;
          col_nxt   = '0;
          side_nxt  = (in_scale == 4'd0) ? 4'd1 : in_scale;
          color_nxt = in_color;
          if (glyph_nxt != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (step) begin
          glyph_nxt = {glyph_r[GLYPH_BITS-2:0], 1'b0};
          if (col_r == 3'(GLYPH_COLS - 1)) begin
            col_nxt   = '0;
            cur_x_nxt = row_x_r;
            cur_y_nxt = cur_y_r + side_c;
          end else begin
            col_nxt   = col_r + 3'd1;
            cur_x_nxt = cur_x_r + side_c;
          end
          if (emit) begin
            out_valid_nxt = 1'b1;
          end
          if (glyph_nxt == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      glyph_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      glyph_r     <= glyph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    row_x_r <= row_x_nxt;
    col_r   <= col_nxt;
    side_r  <= side_nxt;
    color_r <= color_nxt;
    if (emit) begin
      x0_r   <= to_field(cur_x_r);
      y0_r   <= to_field(cur_y_r);
      x1_r   <= to_field(x1_sum);
      y1_r   <= to_field(y1_sum);
      fc_r   <= color_r;
      last_r <= (glyph_r[GLYPH_BITS-2:0] == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rect_x0    = x0_r;
  assign out_rect_y0    = y0_r;
  assign out_rect_x1    = x1_r;
  assign out_rect_y1    = y1_r;
  assign out_fill_color = fc_r;
  assign out_last_rect  = last_r;

`ifndef SYNTHESIS
  a_scan_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) == (glyph_r != '0))
    else $error("scan state and remaining glyph pixels disagree");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (glyph_r[GLYPH_BITS-2:0] == '0) |=> (state_r == ST_IDLE))
    else $error("scan continues after last square");

  a_emit_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (col_r <= 3'(GLYPH_COLS - 1)))
    else $error("column counter out of range");

  a_no_emit_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !emit)
    else $error("square emitted over a stalled result");
`endif

endmodule

>>> verif/tgrg_rect_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tgrg_rect_checker
// Watches both channels of the text glyph rectangle generator. Each accepted
// character is expanded into the squares it should draw, tracking its own
// pen, and every square that leaves the block is compared field by field
// with the oldest one still due.
// ----------------------------------------------------------------------------
module tgrg_rect_checker import tgrg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_start_text,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [3:0]  in_scale,
  input  logic [15:0] in_color,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_rect_x0,
  input  logic [15:0] out_rect_y0,
  input  logic [15:0] out_rect_x1,
  input  logic [15:0] out_rect_y1,
  input  logic [15:0] out_fill_color,
  input  logic        out_last_rect,
  output int          fail_count,
  output int          rects_pending
);

  localparam int GLYPH_BLANK        = 0;
  localparam int GLYPH_FIRST_DIGIT  = 1;
  localparam int GLYPH_FIRST_LETTER = 11;
  localparam int GLYPH_FIRST_PUNCT  = 37;
  localparam int GLYPH_CIRCLED_C    = 47;
  localparam int GLYPH_COUNT        = 48;
  localparam int NUM_DIGITS         = 10;
  localparam int NUM_LETTERS        = 26;
  localparam int NUM_PUNCT          = 10;

  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [8*NUM_PUNCT-1:0] PUNCT_CHARS = "?:.,-+/=()";

  typedef struct packed {
    coord_t      x0;
    coord_t      y0;
    coord_t      x1;
    coord_t      y1;
    logic [15:0] color;
    logic        last_rect;
  } rect_t;

  glyph_t     font_bits [GLYPH_COUNT];
  glyph_idx_t glyph_of  [256];
  rect_t      rects_due [$];
  coord_t     pen_x;
  coord_t     pen_y;

  initial begin
    fail_count    = 0;
    rects_pending = 0;
    pen_x         = '0;
    pen_y         = '0;
    for (int c = 0; c < 256; c++) glyph_of[c] = glyph_idx_t'(GLYPH_BLANK);
    for (int d = 0; d < NUM_DIGITS; d++)
      glyph_of[CH_ZERO + d] = glyph_idx_t'(GLYPH_FIRST_DIGIT + d);
    for (int l = 0; l < NUM_LETTERS; l++) begin
      glyph_of[CH_UPPER_A + l] = glyph_idx_t'(GLYPH_FIRST_LETTER + l);
      glyph_of[CH_LOWER_A + l] = glyph_idx_t'(GLYPH_FIRST_LETTER + l);
    end
    for (int p = 0; p < NUM_PUNCT; p++)
      glyph_of[PUNCT_CHARS[8*(NUM_PUNCT-p)-1 -: 8]] = glyph_idx_t'(GLYPH_FIRST_PUNCT + p);
    glyph_of[CODE_COPYRIGHT] = glyph_idx_t'(GLYPH_CIRCLED_C);

    // rows top to bottom, each row with its leftmost column in the msb
    font_bits[0]  = '0;
    font_bits[1]  = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
    font_bits[2]  = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
    font_bits[3]  = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
    font_bits[4]  = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
    font_bits[5]  = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
    font_bits[6]  = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
    font_bits[7]  = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
    font_bits[8]  = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
    font_bits[9]  = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
    font_bits[10] = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
    font_bits[11] = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
    font_bits[12] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
    font_bits[13] = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
    font_bits[14] = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
    font_bits[15] = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
    font_bits[16] = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
    font_bits[17] = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
    font_bits[18] = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
    font_bits[19] = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
    font_bits[20] = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
    font_bits[21] = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
    font_bits[22] = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
    font_bits[23] = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
    font_bits[24] = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
    font_bits[25] = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
    font_bits[26] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
    font_bits[27] = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
    font_bits[28] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
    font_bits[29] = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
    font_bits[30] = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
    font_bits[31] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
    font_bits[32] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
    font_bits[33] = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
    font_bits[34] = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
    font_bits[35] = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
    font_bits[36] = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
    font_bits[37] = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
    font_bits[38] = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
    font_bits[39] = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04};
    font_bits[40] = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
    font_bits[41] = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
    font_bits[42] = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
    font_bits[43] = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
    font_bits[44] = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
    font_bits[45] = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
    font_bits[46] = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
    font_bits[47] = {5'h0E, 5'h11, 5'h16, 5'h14, 5'h16, 5'h11, 5'h0E};
  end

  task automatic report_fail(input string what);
    $error("%s", what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v)
      report_fail($sformatf("%s: expected %h, got %h", name, exp_v, act_v));
  endtask

  task automatic draw_glyph(input logic [7:0] code, input logic start,
                            input coord_t px, input coord_t py,
                            input logic [3:0] scale, input logic [15:0] color);
    glyph_t cells;
    coord_t side;
    rect_t  held;
    logic   have;
    have = 1'b0;
    held = '0;
    if (start) begin
      pen_x = px;
      pen_y = py;
    end
    side  = (scale == '0) ? coord_t'(1) : coord_t'(scale);
    cells = font_bits[glyph_of[code]];
    for (int row = 0; row < GLYPH_ROWS; row++) begin
      for (int col = 0; col < GLYPH_COLS; col++) begin
        if (cells[GLYPH_BITS-1 - (row*GLYPH_COLS + col)]) begin
          if (have) rects_due.push_back(held);
          held.x0        = pen_x + coord_t'(col) * side;
          held.y0        = pen_y + coord_t'(row) * side;
          held.x1        = held.x0 + side - coord_t'(1);
          held.y1        = held.y0 + side - coord_t'(1);
          held.color     = color;
          held.last_rect = 1'b0;
          have           = 1'b1;
        end
      end
    end
    if (have) begin
      held.last_rect = 1'b1;
      rects_due.push_back(held);
    end
    pen_x = pen_x + coord_t'(CHAR_PITCH) * coord_t'(scale);
  endtask

  task automatic check_rect();
    rect_t exp_r;
    if (rects_due.size() == 0) begin
      report_fail($sformatf("square (%h,%h)-(%h,%h) with none due", out_rect_x0,
                            out_rect_y0, out_rect_x1, out_rect_y1));
    end else begin
      exp_r = rects_due.pop_front();
      check_field("rect_x0", exp_r.x0, out_rect_x0);
      check_field("rect_y0", exp_r.y0, out_rect_y0);
      check_field("rect_x1", exp_r.x1, out_rect_x1);
      check_field("rect_y1", exp_r.y1, out_rect_y1);
      check_field("fill_color", exp_r.color, out_fill_color);
      check_field("last_rect", 16'(exp_r.last_rect), 16'(out_last_rect));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pen_x = '0;
      pen_y = '0;
      rects_due.delete();
    end else begin
      if (in_valid && !in_stall)
        draw_glyph(in_char_code, in_start_text, in_pos_x, in_pos_y, in_scale, in_color);
      if (out_valid && !out_stall) check_rect();
    end
    rects_pending = rects_due.size();
  end

endmodule

>>> verif/tb_text_glyph_rect_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_glyph_rect_generator_unit
// Drives characters into the glyph rectangle generator: a directed set for
// the field extremes, every punctuation glyph, blank codes, zero scale and
// coordinate wrap, then random text strings mixed with noise. Both sides
// idle at random; the checker beside the block predicts every square.
// ----------------------------------------------------------------------------
module tb_text_glyph_rect_generator_unit;
  import tgrg_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_AT      = 150;
  localparam int QUIET_FROM   = 200;
  localparam int QUIET_TO     = 260;
  localparam int PAUSE_AT     = 320;
  localparam int NUM_DIGITS   = 10;
  localparam int NUM_LETTERS  = 26;
  localparam int NUM_PUNCT    = 10;

  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_Z = "z";
  localparam logic [7:0] CH_UPPER_M = "M";
  localparam logic [7:0] CH_EIGHT   = "8";
  localparam logic [7:0] CH_PRINT_LO = "(";
  localparam logic [7:0] CH_PRINT_HI = "Z";
  localparam logic [8*NUM_PUNCT-1:0] PUNCT_CHARS = "?:.,-+/=()";

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = '0;
  logic        in_start_text = 1'b0;
  logic [15:0] in_pos_x = '0;
  logic [15:0] in_pos_y = '0;
  logic [3:0]  in_scale = '0;
  logic [15:0] in_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_rect_x0;
  logic [15:0] out_rect_y0;
  logic [15:0] out_rect_x1;
  logic [15:0] out_rect_y1;
  logic [15:0] out_fill_color;
  logic        out_last_rect;

  int   fail_count;
  int   rects_pending;
  int   items_sent = 0;
  logic in_idle_on = 1'b1;
  logic out_idle_on = 1'b1;
  logic hold_req = 1'b0;

  text_glyph_rect_generator_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_start_text  (in_start_text),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_scale       (in_scale),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rect_x0    (out_rect_x0),
    .out_rect_y0    (out_rect_y0),
    .out_rect_x1    (out_rect_x1),
    .out_rect_y1    (out_rect_y1),
    .out_fill_color (out_fill_color),
    .out_last_rect  (out_last_rect)
  );

  tgrg_rect_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_start_text  (in_start_text),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_scale       (in_scale),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rect_x0    (out_rect_x0),
    .out_rect_y0    (out_rect_y0),
    .out_rect_x1    (out_rect_x1),
    .out_rect_y1    (out_rect_y1),
    .out_fill_color (out_fill_color),
    .out_last_rect  (out_last_rect),
    .fail_count     (fail_count),
    .rects_pending  (rects_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_PRINT_LO + 8'($urandom_range(0, CH_PRINT_HI - CH_PRINT_LO));
      3, 4:    return CH_LOWER_A + 8'($urandom_range(0, NUM_LETTERS - 1));
      5:       return CH_ZERO + 8'($urandom_range(0, NUM_DIGITS - 1));
      6:       return CODE_COPYRIGHT;
      7:       return 8'($urandom_range(0, 255));
      default: return CH_UPPER_A + 8'($urandom_range(0, NUM_LETTERS - 1));
    endcase
  endfunction

  function automatic logic [3:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'd15;
      2:       return 4'($urandom_range(0, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // entered and left at a falling edge; one transfer per call
  task automatic send_char(input logic [7:0] code, input logic start,
                           input logic [15:0] px, input logic [15:0] py,
                           input logic [3:0] scale, input logic [15:0] color);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_char_code  <= code;
    in_start_text <= start;
    in_pos_x      <= px;
    in_pos_y      <= py;
    in_scale      <= scale;
    in_color      <= color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (out_idle_on && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(15, 50);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [3:0]  str_scale;
    logic [15:0] str_color;
    logic [15:0] str_x;
    logic [15:0] str_y;
    logic        hold_done;
    logic        pause_done;
    int          str_len;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    send_char(CH_UPPER_A, 1'b1, 16'h0000, 16'h0000, 4'd1, 16'hFFFF);
    send_char(CH_LOWER_Z, 1'b0, 16'hFFFF, 16'hFFFF, 4'd2, 16'h0000);
    send_char(CH_ZERO, 1'b0, 16'h5555, 16'hAAAA, 4'd0, 16'h1234);
    send_char(8'h00, 1'b0, 16'h0000, 16'h0000, 4'd3, 16'hFFFF);
    send_char(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 4'd15, 16'h0000);
    send_char(CH_ZERO, 1'b0, 16'h0000, 16'h0000, 4'd1, 16'hA5A5);
    send_char(CODE_COPYRIGHT, 1'b1, 16'h7FF0, 16'h7FF8, 4'd15, 16'hF800);
    send_char(CH_EIGHT, 1'b1, 16'h8000, 16'h8000, 4'd15, 16'h07E0);
    send_char(CH_UPPER_M, 1'b1, 16'h7FFF, 16'h7FFF, 4'd3, 16'h001F);
    send_char(CH_UPPER_M, 1'b1, 16'hFFFE, 16'hFFFD, 4'd14, 16'h5A5A);
    for (int p = 0; p < NUM_PUNCT; p++)
      send_char(PUNCT_CHARS[8*(NUM_PUNCT-p)-1 -: 8], p == 0, 16'hFFF0, 16'h0010,
                4'(p + 1), 16'($urandom));

    // random text strings with some noise
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      in_idle_on  = !(items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      out_idle_on = in_idle_on;
      if (!pause_done && items_sent >= PAUSE_AT) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        wait (rects_pending == 0);
        @(negedge clk);
      end
      if ($urandom_range(0, 9) < 8) begin
        str_len   = $urandom_range(1, 12);
        str_scale = pick_scale();
        str_color = 16'($urandom);
        str_x     = 16'($urandom);
        str_y     = 16'($urandom);
        for (int k = 0; k < str_len; k++) begin
          if ($urandom_range(0, 7) == 0) str_color = 16'($urandom);
          send_char(pick_char(), k == 0, (k == 0) ? str_x : 16'($urandom),
                    (k == 0) ? str_y : 16'($urandom), str_scale, str_color);
        end
      end else begin
        send_char(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                  4'($urandom), 16'($urandom));
      end
    end

    in_valid <= 1'b0;
    out_idle_on = 1'b0;
    wait (rects_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tgrg_pkg.sv
design/text_glyph_rect_generator_unit.sv
verif/tgrg_rect_checker.sv
verif/tb_text_glyph_rect_generator_unit.sv
